@@ hw/rtl/hts_pkg.sv @@
// ----------------------------------------------------------------------------
// hts_pkg: shared types and constants for the HTML text stripper
// Scan modes, result records, and the tag name tables for hidden blocks.
// ----------------------------------------------------------------------------
package hts_pkg;

    typedef enum logic [1:0] {
        MODE_NORMAL = 2'd0,
        MODE_NAME   = 2'd1,
        MODE_BLOCK  = 2'd2,
        MODE_WAIT   = 2'd3
    } t_scan_mode;

    // Hidden block tag indexes
    localparam logic [1:0] TAG_SCRIPT   = 2'd0;
    localparam logic [1:0] TAG_STYLE    = 2'd1;
    localparam logic [1:0] TAG_NOSCRIPT = 2'd2;
    localparam logic [1:0] TAG_SVG      = 2'd3;

    localparam logic [7:0] CH_LT    = 8'h3C;
    localparam logic [7:0] CH_GT    = 8'h3E;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_SPACE = 8'h20;

    // Result queue depth and occupancy width
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_valid;
        logic       end_of_text;
    } t_result;

    typedef struct packed {
        logic [1:0] cnt;
        t_result    r0;
        t_result    r1;
    } t_push;

    function automatic logic [3:0] tag_len(input logic [1:0] t);
        logic [3:0] l;
        case (t)
            TAG_SCRIPT:   l = 4'd6;
            TAG_STYLE:    l = 4'd5;
            TAG_NOSCRIPT: l = 4'd8;
            TAG_SVG:      l = 4'd3;
            default:      l = 4'd0;
        endcase
        return l;
    endfunction

    function automatic logic [7:0] name_char(input logic [1:0] t, input logic [2:0] k);
        logic [63:0] s;
        case (t)
            TAG_SCRIPT:   s = {"script", 16'h0};
            TAG_STYLE:    s = {"style", 24'h0};
            TAG_NOSCRIPT: s = "noscript";
            TAG_SVG:      s = {"svg", 40'h0};
            default:      s = '0;
        endcase
        // first character sits in the top byte
        return s[(7 - k) * 8 +: 8];
    endfunction

    function automatic logic [7:0] close_char(input logic [1:0] t, input logic [3:0] k);
        logic [7:0] c;
        logic [3:0] j;
        j = k - 4'd2;
        if (k == 4'd0) begin
            c = CH_LT;
        end else if (k == 4'd1) begin
            c = CH_SLASH;
        end else begin
            c = name_char(t, j[2:0]);
        end
        return c;
    endfunction

endpackage

@@ hw/rtl/hts_if.sv @@
// ----------------------------------------------------------------------------
// hts_if: request channels of the HTML text stripper
// Input byte channel and cleaned text channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface hts_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       last_byte;

    modport source (output valid, in_byte, last_byte, input ready);
    modport sink   (input valid, in_byte, last_byte, output ready);
endinterface

interface hts_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       end_of_text;

    modport source (output valid, out_byte, byte_valid, end_of_text, input ready);
    modport sink   (input valid, out_byte, byte_valid, end_of_text, output ready);
endinterface

@@ hw/rtl/hts_core.sv @@
// ----------------------------------------------------------------------------
// hts_core: scan engine of the HTML text stripper
// Registers one input byte, runs the tag / hidden block scanner on it and
// hands zero, one or two results to the result queue.
// ----------------------------------------------------------------------------
module hts_core (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_take,
    input  logic [7:0]    i_byte,
    input  logic          i_last,
    input  logic          i_room,
    output logic          o_busy,
    output hts_pkg::t_push o_push
);
    import hts_pkg::*;

    logic       r_in_vld;
    logic [7:0] r_in_byte;
    logic       r_in_last;

    t_scan_mode r_mode, n_mode;
    logic [3:0] r_live, n_live;
    logic [3:0] r_pos, n_pos;
    logic [1:0] r_tag, n_tag;
    logic [3:0] r_prog, n_prog;
    logic       r_inside, n_inside;
    logic       r_emitted, n_emitted;
    logic       r_space, n_space;

    logic       fire;
    logic [7:0] c;
    logic [7:0] lc;
    logic       ws;
    logic       normal;
    logic [3:0] nl;
    logic       hit;
    logic [1:0] hit_tag;
    logic [3:0] plen;
    logic [3:0] np;
    t_push      push;

    assign fire   = r_in_vld && i_room;
    assign o_busy = r_in_vld;
    assign c      = r_in_byte;

    always_comb begin
        lc = (c >= 8'h41 && c <= 8'h5A) ? c + 8'h20 : c;
        ws = c inside {CH_SPACE, [8'h09:8'h0D]};

        n_mode    = r_mode;
        n_live    = r_live;
        n_pos     = r_pos;
        n_tag     = r_tag;
        n_prog    = r_prog;
        n_inside  = r_inside;
        n_emitted = r_emitted;
        n_space   = r_space;
        normal    = 1'b0;
        nl        = '0;
        hit       = 1'b0;
        hit_tag   = '0;
        plen      = tag_len(r_tag) + 4'd2;
        np        = '0;
        push      = '0;

        case (r_mode)
            MODE_NAME: begin
                for (int t = 0; t < 4; t++) begin
                    if (r_live[t]) begin
                        if (r_pos < tag_len(2'(t))) begin
                            if (name_char(2'(t), r_pos[2:0]) == lc) nl[t] = 1'b1;
                        end else if (r_pos == tag_len(2'(t)) && (c == CH_GT || ws)) begin
                            hit     = 1'b1;
                            hit_tag = 2'(t);
                        end
                    end
                end
                if (hit) begin
                    n_mode = MODE_BLOCK;
                    n_tag  = hit_tag;
                    n_prog = '0;
                    n_live = '0;
                    n_pos  = '0;
                end else if (nl != '0) begin
                    n_live = nl;
                    n_pos  = r_pos + 4'd1;
                end else begin
                    // no hidden name: treat the '<' as an ordinary tag
                    n_inside = 1'b1;
                    if (r_emitted) n_space = 1'b1;
                    n_mode = MODE_NORMAL;
                    n_live = '0;
                    n_pos  = '0;
                    normal = 1'b1;
                end
            end
            MODE_BLOCK: begin
                if (r_prog < plen && lc == close_char(r_tag, r_prog)) begin
                    np = r_prog + 4'd1;
                end else begin
                    np = (c == CH_LT) ? 4'd1 : 4'd0;
                end
                if (np >= plen) begin
                    n_mode = MODE_WAIT;
                    n_prog = '0;
                end else begin
                    n_prog = np;
                end
            end
            MODE_WAIT: begin
                if (c == CH_GT) n_mode = MODE_NORMAL;
            end
            default: begin
                normal = 1'b1;
            end
        endcase

        if (normal) begin
            if (c == CH_LT) begin
                n_mode = MODE_NAME;
                n_live = 4'hF;
                n_pos  = '0;
            end else if (c == CH_GT) begin
                n_inside = 1'b0;
            end else if (n_inside) begin
                // drop tag contents
            end else if (ws) begin
                if (r_emitted) n_space = 1'b1;
            end else begin
                if (n_space) begin
                    push.r0  = '{out_byte: CH_SPACE, byte_valid: 1'b1, end_of_text: 1'b0};
                    push.r1  = '{out_byte: c, byte_valid: 1'b1, end_of_text: 1'b0};
                    push.cnt = 2'd2;
                end else begin
                    push.r0  = '{out_byte: c, byte_valid: 1'b1, end_of_text: 1'b0};
                    push.cnt = 2'd1;
                end
                n_emitted = 1'b1;
                n_space   = 1'b0;
            end
        end

        if (r_in_last) begin
            case (push.cnt)
                2'd0: begin
                    push.r0  = '{out_byte: 8'h00, byte_valid: 1'b0, end_of_text: 1'b1};
                    push.cnt = 2'd1;
                end
                2'd1:    push.r0.end_of_text = 1'b1;
                default: push.r1.end_of_text = 1'b1;
            endcase
            // back to reset state for the next document
            n_mode    = MODE_NORMAL;
            n_live    = '0;
            n_pos     = '0;
            n_tag     = '0;
            n_prog    = '0;
            n_inside  = 1'b0;
            n_emitted = 1'b0;
            n_space   = 1'b0;
        end

        o_push = push;
        if (!fire) o_push.cnt = 2'd0;
    end

    always_ff @(posedge i_clk) begin
        if (i_take) begin
            r_in_byte <= i_byte;
            r_in_last <= i_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_mode    <= MODE_NORMAL;
            r_live    <= '0;
            r_pos     <= '0;
            r_tag     <= '0;
            r_prog    <= '0;
            r_inside  <= 1'b0;
            r_emitted <= 1'b0;
            r_space   <= 1'b0;
        end else begin
            if (i_take) begin
                r_in_vld <= 1'b1;
            end else if (fire) begin
                r_in_vld <= 1'b0;
            end
            if (fire) begin
                r_mode    <= n_mode;
                r_live    <= n_live;
                r_pos     <= n_pos;
                r_tag     <= n_tag;
                r_prog    <= n_prog;
                r_inside  <= n_inside;
                r_emitted <= n_emitted;
                r_space   <= n_space;
            end
        end
    end

endmodule

@@ hw/rtl/hts_outq.sv @@
// ----------------------------------------------------------------------------
// hts_outq: result queue of the HTML text stripper
// Takes up to two results a cycle, gives one a cycle to the output channel while that channel is ready.
// ----------------------------------------------------------------------------
module hts_outq (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  hts_pkg::t_push        i_push,
    input  logic                  i_pop,
    output logic                  o_room,
    output logic                  o_vld,
    output hts_pkg::t_result      o_head,
    output logic [hts_pkg::QCNT_W-1:0] o_count
);
    import hts_pkg::*;

    t_result             r_mem [QDEPTH];
    logic [QPTR_W-1:0]   r_wr, n_wr;
    logic [QPTR_W-1:0]   r_rd, n_rd;
    logic [QCNT_W-1:0]   r_cnt, n_cnt;
    logic [QPTR_W-1:0]   wr1;
    logic                pop;

    assign pop     = i_pop && (r_cnt != '0);
    assign wr1     = r_wr + QPTR_W'(1);
    assign o_room  = r_cnt <= QCNT_W'(QDEPTH - 2);
    assign o_vld   = r_cnt != '0;
    assign o_head  = r_mem[r_rd];
    assign o_count = r_cnt;

    always_comb begin
        n_wr  = r_wr + QPTR_W'(i_push.cnt);
        n_rd  = pop ? r_rd + QPTR_W'(1) : r_rd;
        n_cnt = r_cnt + QCNT_W'(i_push.cnt) - QCNT_W'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (i_push.cnt != 2'd0) r_mem[r_wr] <= i_push.r0;
        if (i_push.cnt == 2'd2) r_mem[wr1]  <= i_push.r1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

endmodule

@@ hw/rtl/html_text_stripper.sv @@
// ----------------------------------------------------------------------------
// html_text_stripper: HTML to readable text filter
// Top level: input byte register, scan engine and result queue.
// ----------------------------------------------------------------------------
// One HTML byte is accepted per cycle while the input is ready. Each byte
// waits in the input register, where the scanner decides its results, and
// reaches the output channel through the result queue. A byte gives no
// result, one, or two (a pending space and the text byte); the output port
// delivers one result per cycle while its sink is ready, so input is taken
// at one byte per cycle while the text carries no more than one result per
// byte on average, and input back-pressure follows from the four-entry queue.
module html_text_stripper (
    input  logic     i_clk,
    input  logic     i_rst_n,
    hts_in_if.sink   i_in,
    hts_out_if.source o_out
);
    import hts_pkg::*;

    logic              busy;
    logic              room;
    logic              take;
    logic              pop;
    t_push             push;
    t_result           head;
    logic [QCNT_W-1:0] q_count;

    assign i_in.ready = !busy || room;
    assign take       = i_in.valid && i_in.ready;
    assign pop        = o_out.valid && o_out.ready;

    hts_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_take  (take),
        .i_byte  (i_in.in_byte),
        .i_last  (i_in.last_byte),
        .i_room  (room),
        .o_busy  (busy),
        .o_push  (push)
    );

    hts_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_pop   (pop),
        .o_room  (room),
        .o_vld   (o_out.valid),
        .o_head  (head),
        .o_count (q_count)
    );

    assign o_out.out_byte    = head.out_byte;
    assign o_out.byte_valid  = head.byte_valid;
    assign o_out.end_of_text = head.end_of_text;

    // queue never holds more than its depth
    a_q_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_count <= QCNT_W'(QDEPTH))
        else $error("result queue overfilled");

    // results are only written while the queue has room for two
    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push.cnt != 2'd0 |-> room)
        else $error("push without room");

    // a bare end mark always closes the document with a zero byte
    a_bare_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && !o_out.byte_valid |-> o_out.end_of_text && o_out.out_byte == 8'h00)
        else $error("bare result without end mark");

    // a space result is always followed in the queue by a text byte
    a_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push.cnt == 2'd2 |-> push.r0.out_byte == CH_SPACE && push.r1.byte_valid)
        else $error("malformed result pair");

endmodule
